// ----- design/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// Depends on nothing; every other design file imports it.
package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int MW = OPERAND_WIDTH;          // operand magnitude width
   localparam int PW = 2 * MW;                 // product width
   localparam int SW = PW + 1;                 // width of sums and reduced values
   localparam int XW = (SW > 32) ? SW : 32;    // width used for the output sign step
   localparam int KW = $clog2(SW);             // shared power of two counter width
   localparam int CW = $clog2(SW + 1);         // divider bit counter width
   localparam int RES_NUM_W = 32;
   localparam int RES_DEN_W = 30;

   typedef enum logic [2:0] {
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_EQ, CMD_GT, CMD_LT, CMD_NORM
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic signed [MW-1:0]   a_num;
      logic signed [MW-1:0]   a_den;
      logic signed [MW-1:0]   b_num;
      logic signed [MW-1:0]   b_den;
   } req_type;

   typedef struct packed {
      logic signed [RES_NUM_W-1:0] res_num;
      logic [RES_DEN_W-1:0]        res_den;
      logic                        compare_true;
      logic                        div_by_zero;
   } rsp_type;

   // Classified transaction as held in the queue: sign and magnitudes.
   typedef struct packed {
      cmd_type       cmd;
      logic          a_neg;
      logic [MW-1:0] a_mag;
      logic [MW-1:0] a_den;
      logic          b_neg;
      logic [MW-1:0] b_mag;
      logic [MW-1:0] b_den;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RED_INIT, ST_GCD, ST_DIV_NUM, ST_WAIT_NUM, ST_DIV_DEN,
      ST_WAIT_DEN, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMBINE, ST_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      PH_A, PH_B, PH_R
   } phase_type;

endpackage

// ----- design/rau_front.sv -----
// Front end: accepts transactions, splits operands into sign and magnitude,
// and holds them in a two-entry queue for the back end. Uses rau_pkg.
module rau_front import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_data,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   item_type   cls;

   function automatic logic [MW:0] split(input logic [MW-1:0] v);
      logic [MW-1:0] m;
      m = v[MW-1] ? (~v + MW'(1)) : v;
      return {v[MW-1], m};
   endfunction

   always_comb begin
      logic [MW:0] an, ad, bn, bd;
      an = split(req_data.a_num);
      ad = split(req_data.a_den);
      bn = split(req_data.b_num);
      bd = split(req_data.b_den);
      cls.cmd   = req_data.cmd;
      cls.a_mag = an[MW-1:0];
      cls.b_mag = bn[MW-1:0];
      cls.a_neg = (an[MW] ^ ad[MW]) && (an[MW-1:0] != '0);
      cls.b_neg = (bn[MW] ^ bd[MW]) && (bn[MW-1:0] != '0);
      // A zero denominator counts as one, and a zero fraction is 0/1.
      cls.a_den = (ad[MW-1:0] == '0 || an[MW-1:0] == '0) ? MW'(1) : ad[MW-1:0];
      cls.b_den = (bd[MW-1:0] == '0 || bn[MW-1:0] == '0) ? MW'(1) : bd[MW-1:0];
   end

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign pop     = q_pop && (count_ff != 2'd0);
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- design/rau_div.sv -----
// Restoring divider, one quotient bit per cycle, for exact reductions.
// Uses rau_pkg for its widths.
module rau_div import rau_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [SW-1:0] dividend,
   input  logic [SW-1:0] divisor,
   output logic          done,
   output logic [SW-1:0] quotient
);

   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [SW-1:0] dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [SW:0]   trial, diff;

   assign trial = {rem_ff, quo_ff[SW-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CW'(SW);
      end else if (cnt_ff != '0) begin
         if (!diff[SW]) begin
            rem_in = diff[SW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = trial[SW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- design/rau_back.sv -----
// Back end: reduces operands, forms cross products, combines and reduces
// the result. Uses rau_pkg and rau_div.
module rau_back import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   back_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   item_type       item_ff, item_in;
   logic           a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic [MW-1:0]  a_mag_ff, a_mag_in, a_den_ff, a_den_in;
   logic [MW-1:0]  b_mag_ff, b_mag_in, b_den_ff, b_den_in;
   logic [PW-1:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic           r_neg_ff, r_neg_in;
   logic [SW-1:0]  r_mag_ff, r_mag_in, r_den_ff, r_den_in;
   logic [SW-1:0]  u_ff, u_in, v_ff, v_in, g_ff, g_in, qn_ff, qn_in;
   logic [KW-1:0]  k_ff, k_in;
   logic           cmp_ff, cmp_in, dz_ff, dz_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   logic           red_neg;
   logic [SW-1:0]  red_mag, red_den;
   logic           div_start, div_done;
   logic [SW-1:0]  div_dividend, div_quo;
   logic [MW-1:0]  mul_x, mul_y;
   logic [PW-1:0]  prod;
   logic           red_zero, gcd_end;

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      case (phase_ff)
         PH_A: begin
            red_neg = a_neg_ff;
            red_mag = SW'(a_mag_ff);
            red_den = SW'(a_den_ff);
         end
         PH_B: begin
            red_neg = b_neg_ff;
            red_mag = SW'(b_mag_ff);
            red_den = SW'(b_den_ff);
         end
         default: begin
            red_neg = r_neg_ff;
            red_mag = r_mag_ff;
            red_den = r_den_ff;
         end
      endcase
   end

   assign red_zero     = (red_mag == '0);
   assign gcd_end      = (u_ff == v_ff);
   assign div_start    = (state_ff == ST_DIV_NUM) || (state_ff == ST_DIV_DEN);
   assign div_dividend = (state_ff == ST_DIV_NUM) ? red_mag : red_den;
   assign prod         = PW'(mul_x) * PW'(mul_y);

   always_comb begin
      case (state_ff)
         ST_MUL0: begin
            mul_x = a_mag_ff;
            mul_y = (item_ff.cmd == CMD_MUL) ? b_mag_ff : b_den_ff;
         end
         ST_MUL1: begin
            mul_x = b_mag_ff;
            mul_y = a_den_ff;
         end
         default: begin
            mul_x = a_den_ff;
            mul_y = (item_ff.cmd == CMD_DIV) ? b_mag_ff : b_den_ff;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (q_valid) state_in = ST_RED_INIT;
         ST_RED_INIT: state_in = red_zero ? ((phase_ff == PH_R) ? ST_OUT :
                                 (phase_ff == PH_A) ? ST_RED_INIT : ST_MUL0) : ST_GCD;
         ST_GCD:      if (gcd_end) state_in = ST_DIV_NUM;
         ST_DIV_NUM:  state_in = ST_WAIT_NUM;
         ST_WAIT_NUM: if (div_done) state_in = ST_DIV_DEN;
         ST_DIV_DEN:  state_in = ST_WAIT_DEN;
         ST_WAIT_DEN: if (div_done) begin
            case (phase_ff)
               PH_A:    state_in = ST_RED_INIT;
               PH_B:    state_in = ST_MUL0;
               default: state_in = ST_OUT;
            endcase
         end
         ST_MUL0:     state_in = ST_MUL1;
         ST_MUL1:     state_in = ST_MUL2;
         ST_MUL2:     state_in = ST_COMBINE;
         ST_COMBINE: begin
            case (item_ff.cmd)
               CMD_ADD, CMD_SUB, CMD_MUL: state_in = ST_RED_INIT;
               CMD_DIV: state_in = (b_mag_ff == '0) ? ST_OUT : ST_RED_INIT;
               default: state_in = ST_OUT;
            endcase
         end
         ST_OUT:      state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      logic          n2;
      logic [SW-1:0] s0, s1;
      logic          eq, gt;
      logic [XW-1:0] xv;
      n2 = b_neg_ff ^ (item_ff.cmd == CMD_SUB);
      s0 = SW'(p0_ff);
      s1 = SW'(p1_ff);
      eq = (a_neg_ff == b_neg_ff) && (p0_ff == p1_ff);
      gt = (a_neg_ff != b_neg_ff) ? !a_neg_ff :
           (a_neg_ff ? (p0_ff < p1_ff) : (p0_ff > p1_ff));
      xv = XW'(r_mag_ff);
      if (r_neg_ff) xv = ~xv + XW'(1);

      q_pop = 1'b0;
      phase_in = phase_ff;
      item_in = item_ff;
      a_neg_in = a_neg_ff; a_mag_in = a_mag_ff; a_den_in = a_den_ff;
      b_neg_in = b_neg_ff; b_mag_in = b_mag_ff; b_den_in = b_den_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      r_neg_in = r_neg_ff; r_mag_in = r_mag_ff; r_den_in = r_den_ff;
      u_in = u_ff; v_in = v_ff; g_in = g_ff; qn_in = qn_ff; k_in = k_ff;
      cmp_in = cmp_ff; dz_in = dz_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;

      case (state_ff)
         ST_IDLE: if (q_valid) begin
            q_pop    = 1'b1;
            item_in  = q_item;
            a_neg_in = q_item.a_neg; a_mag_in = q_item.a_mag; a_den_in = q_item.a_den;
            b_neg_in = q_item.b_neg; b_mag_in = q_item.b_mag; b_den_in = q_item.b_den;
            phase_in = PH_A;
            cmp_in   = 1'b0;
            dz_in    = 1'b0;
         end
         ST_RED_INIT: begin
            if (red_zero) begin
               // A zero fraction is already 0/1; only the result needs it here.
               r_neg_in = 1'b0;
               r_mag_in = '0;
               r_den_in = SW'(1);
               if (phase_ff == PH_A) phase_in = PH_B;
            end else begin
               u_in = red_mag;
               v_in = red_den;
               k_in = '0;
            end
         end
         ST_GCD: begin
            if (gcd_end) begin
               g_in = u_ff << k_ff;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + KW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = (u_ff - v_ff) >> 1;
            end else begin
               v_in = (v_ff - u_ff) >> 1;
            end
         end
         ST_WAIT_NUM: if (div_done) qn_in = div_quo;
         ST_WAIT_DEN: if (div_done) begin
            case (phase_ff)
               PH_A: begin
                  a_mag_in = qn_ff[MW-1:0];
                  a_den_in = div_quo[MW-1:0];
                  phase_in = PH_B;
               end
               PH_B: begin
                  b_mag_in = qn_ff[MW-1:0];
                  b_den_in = div_quo[MW-1:0];
               end
               default: begin
                  r_neg_in = red_neg;
                  r_mag_in = qn_ff;
                  r_den_in = div_quo;
               end
            endcase
         end
         ST_MUL0: p0_in = prod;
         ST_MUL1: p1_in = prod;
         ST_MUL2: p2_in = prod;
         ST_COMBINE: begin
            phase_in = PH_R;
            r_den_in = SW'(p2_ff);
            case (item_ff.cmd)
               CMD_ADD, CMD_SUB: begin
                  if (a_neg_ff == n2) begin
                     r_neg_in = a_neg_ff;
                     r_mag_in = s0 + s1;
                  end else if (s0 >= s1) begin
                     r_neg_in = a_neg_ff;
                     r_mag_in = s0 - s1;
                  end else begin
                     r_neg_in = n2;
                     r_mag_in = s1 - s0;
                  end
               end
               CMD_MUL, CMD_DIV: begin
                  r_neg_in = a_neg_ff ^ b_neg_ff;
                  r_mag_in = s0;
                  if (item_ff.cmd == CMD_DIV && b_mag_ff == '0) begin
                     dz_in    = 1'b1;
                     r_neg_in = 1'b0;
                     r_mag_in = '0;
                     r_den_in = SW'(1);
                  end
               end
               CMD_EQ, CMD_GT, CMD_LT: begin
                  r_neg_in = 1'b0;
                  r_mag_in = '0;
                  r_den_in = SW'(1);
                  case (item_ff.cmd)
                     CMD_EQ:  cmp_in = eq;
                     CMD_GT:  cmp_in = gt;
                     default: cmp_in = !eq && !gt;
                  endcase
               end
               default: begin
                  r_neg_in = a_neg_ff;
                  r_mag_in = SW'(a_mag_ff);
                  r_den_in = SW'(a_den_ff);
               end
            endcase
         end
         ST_OUT: begin
            rsp_valid_in         = 1'b1;
            rsp_in.res_num       = xv[RES_NUM_W-1:0];
            rsp_in.res_den       = RES_DEN_W'(r_den_ff);
            rsp_in.compare_true  = cmp_ff;
            rsp_in.div_by_zero   = dz_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff <= phase_in;
      item_ff  <= item_in;
      a_neg_ff <= a_neg_in; a_mag_ff <= a_mag_in; a_den_ff <= a_den_in;
      b_neg_ff <= b_neg_in; b_mag_ff <= b_mag_in; b_den_ff <= b_den_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
      r_neg_ff <= r_neg_in; r_mag_ff <= r_mag_in; r_den_ff <= r_den_in;
      u_ff <= u_in; v_ff <= v_in; g_ff <= g_in; qn_ff <= qn_in; k_ff <= k_in;
      cmp_ff <= cmp_in; dz_ff <= dz_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/rational_arithmetic_unit_core.sv -----
// Top level of the rational arithmetic unit: front end, queue and back end.
// Depends on rau_pkg, rau_front, rau_back and rau_div.
//
// A transaction carries an operation code and two fractions; it is taken at a
// rising clock edge with start high and busy low. Both fractions are first
// brought to normal form (sign on the numerator, zero denominator read as one,
// zero numerator as 0/1, reduced by their greatest common divisor), then the
// block adds, subtracts, multiplies, divides, compares by cross
// multiplication, or returns the normalized first fraction. Results are
// reduced the same way. Division by a zero fraction returns 0/1 with
// div_by_zero set; compares return 0/1 with compare_true giving the outcome.
// Each result appears on rsp_data for exactly one cycle with rsp_valid high;
// the receiver cannot stall it, so it must capture it in that cycle. The
// front end holds up to two waiting transactions and raises busy when full.
// The time a transaction spends in the back end depends on the data: each
// of up to three reductions runs a binary GCD loop (one subtract or shift
// per cycle) followed by two exact divisions on a bit-serial divider, which
// loads its operands, forms the 33 quotient bits in turn and then signals
// done; the products use the shared 16 by 16 multiplier. When both
// fractions are zero no reduction runs. The result strobe follows in the
// cycle after the last back end state. Results leave in arrival order.
module rational_arithmetic_unit_core import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   // The front end classifies each transaction and queues it.
   rau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   // The back end takes one queued transaction at a time and computes it.
   rau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // ST_OUT is followed by ST_IDLE, so strobes never come back to back.
   a_no_double_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe on two consecutive cycles");

   // A division by zero always reports the fraction 0/1.
   a_dz_zero_frac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_by_zero) |->
         (rsp_data.res_num == '0 && rsp_data.res_den == RES_DEN_W'(1)
          && !rsp_data.compare_true))
      else $error("division by zero result is not 0/1");

   // A true compare returns 0/1.
   a_cmp_zero_frac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.compare_true) |->
         (rsp_data.res_num == '0 && rsp_data.res_den == RES_DEN_W'(1)))
      else $error("compare result is not 0/1");

   // The queue is taken only while it holds a transaction.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

endmodule
